FILE: rtl/core/lprp_pkg.sv
package lprp_pkg;

  localparam int DEF_MAX_MESSAGE = 4096;
  localparam int DEF_MAX_ARGS    = 1024;

  localparam int CFG_MSG_W  = 13;
  localparam int CFG_ARGS_W = 11;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MESSAGE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ARGS    = 1'd1;

  localparam logic [CFG_MSG_W-1:0]  RST_MAX_MESSAGE = 13'd4096;
  localparam logic [CFG_ARGS_W-1:0] RST_MAX_ARGS    = 11'd1024;

  localparam int IDX_W = 10;

  localparam logic [31:0] MIN_LEN = 32'd4;

  localparam logic [1:0] KIND_ARG_BYTE  = 2'd0;
  localparam logic [1:0] KIND_EMPTY_ARG = 2'd1;
  localparam logic [1:0] KIND_EMPTY_MSG = 2'd2;
  localparam logic [1:0] KIND_ERROR     = 2'd3;

  localparam logic ERR_TOO_LONG  = 1'b0;
  localparam logic ERR_MALFORMED = 1'b1;

  typedef enum logic [1:0] {
    PH_LEN,
    PH_COUNT,
    PH_ALEN,
    PH_DATA
  } phase_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       arg_byte;
    logic [IDX_W-1:0] arg_index;
    logic             arg_end;
    logic             message_end;
    logic             error_code;
  } result_t;

endpackage

FILE: rtl/core/lprp_byte_if.sv
interface lprp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

FILE: rtl/core/lprp_result_if.sv
interface lprp_result_if
  import lprp_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [7:0]       arg_byte;
  logic [IDX_W-1:0] arg_index;
  logic             arg_end;
  logic             message_end;
  logic             error_code;

  modport source (
    output valid, output kind, output arg_byte, output arg_index,
    output arg_end, output message_end, output error_code, input ready
  );
  modport sink (
    input valid, input kind, input arg_byte, input arg_index,
    input arg_end, input message_end, input error_code, output ready
  );
endinterface

FILE: rtl/core/length_prefixed_request_parser_core.sv
// Length-prefixed request parser.
// req carries the request stream, one byte per beat. Each message is a
// 32-bit little-endian body length, a 32-bit argument count and then the
// arguments, each a 32-bit length followed by its bytes.
// res carries one beat per argument byte, per empty argument, per message
// without arguments and one for the first framing error; bytes that only
// build up a length or count field give no beat.
// A byte accepted on req passes the input register and then the parse logic
// into the result register, from which res carries any beat that it gives.
// Throughput: one byte per cycle while res is not stalled by the receiver.
// A full result register still takes a new byte whenever res.ready is high
// in the same cycle; when the receiver stalls, one byte more is held at the
// input and then req.ready drops until res moves.
// After an error beat the parser drops every byte until reset.
// Reset (rst, synchronous) empties both registers, clears the parse state and sets
// the limits to 4096 bytes and 1024 arguments. Write limits with cfg_we,
// cfg_index and cfg_data only while the stream is idle.
module length_prefixed_request_parser_core
  import lprp_pkg::*;
#(
  parameter int MAX_MESSAGE = DEF_MAX_MESSAGE,
  parameter int MAX_ARGS    = DEF_MAX_ARGS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lprp_byte_if.sink             req,
  lprp_result_if.source         res
);

  logic [CFG_MSG_W-1:0]  max_message_bytes;
  logic [CFG_ARGS_W-1:0] max_arguments;

  logic       held_valid;
  logic [7:0] held_byte;
  logic       out_free;
  logic       take;
  logic       dec_valid;
  result_t    dec_res;

  logic    out_valid;
  result_t out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_message_bytes <= RST_MAX_MESSAGE;
      max_arguments     <= RST_MAX_ARGS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_MESSAGE: max_message_bytes <= cfg_data[CFG_MSG_W-1:0];
        CFG_MAX_ARGS:    max_arguments     <= cfg_data[CFG_ARGS_W-1:0];
        default:         ;
      endcase
    end
  end

  assign out_free = !out_valid || res.ready;
  assign take     = held_valid && out_free;

  lprp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  lprp_decode #(
    .MAX_MESSAGE (MAX_MESSAGE),
    .MAX_ARGS    (MAX_ARGS)
  ) u_decode (
    .clk               (clk),
    .rst               (rst),
    .step              (take),
    .data_byte         (held_byte),
    .max_message_bytes (max_message_bytes),
    .max_arguments     (max_arguments),
    .res_valid         (dec_valid),
    .res               (dec_res)
  );

  // Load a new result beat whenever the register is empty or being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= take && dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && dec_valid) begin
      out_data <= dec_res;
    end
  end

  assign res.valid       = out_valid;
  assign res.kind        = out_data.kind;
  assign res.arg_byte    = out_data.arg_byte;
  assign res.arg_index   = out_data.arg_index;
  assign res.arg_end     = out_data.arg_end;
  assign res.message_end = out_data.message_end;
  assign res.error_code  = out_data.error_code;

endmodule

FILE: rtl/core/lprp_in_stage.sv
module lprp_in_stage (
  input  logic        clk,
  input  logic        rst,
  lprp_byte_if.sink   req,
  input  logic        take,
  output logic        held_valid,
  output logic [7:0]  held_byte
);

  logic       valid;
  logic [7:0] data;

  // Accept a new beat whenever the held one is empty or leaves this cycle.
  assign req.ready  = !valid || take;
  assign held_valid = valid;
  assign held_byte  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (req.ready) begin
      valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      data <= req.data_byte;
    end
  end

endmodule

FILE: rtl/core/lprp_decode.sv
module lprp_decode
  import lprp_pkg::*;
#(
  parameter int MAX_MESSAGE = DEF_MAX_MESSAGE,
  parameter int MAX_ARGS    = DEF_MAX_ARGS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            data_byte,
  input  logic [CFG_MSG_W-1:0]  max_message_bytes,
  input  logic [CFG_ARGS_W-1:0] max_arguments,
  output logic                  res_valid,
  output result_t               res
);

  localparam int MSG_FULL = (1 << CFG_MSG_W) - 1;
  localparam int ARG_FULL = (1 << CFG_ARGS_W) - 1;
  localparam int MSG_CAP  = (MAX_MESSAGE < MSG_FULL) ? MAX_MESSAGE : MSG_FULL;
  localparam int ARG_CAP  = (MAX_ARGS < ARG_FULL) ? MAX_ARGS : ARG_FULL;
  localparam int MW       = $clog2(MSG_CAP + 1);
  localparam int AW       = $clog2(ARG_CAP + 1);

  localparam logic [CFG_MSG_W-1:0]  MSG_CAP_C = CFG_MSG_W'(MSG_CAP);
  localparam logic [CFG_ARGS_W-1:0] ARG_CAP_C = CFG_ARGS_W'(ARG_CAP);

  phase_t           phase, phase_next;
  logic [1:0]       field_byte_count, field_byte_count_next;
  logic [23:0]      field_shift, field_shift_next;
  logic [MW-1:0]    message_remaining, message_remaining_next;
  logic [AW-1:0]    args_remaining, args_remaining_next;
  logic [IDX_W-1:0] current_arg, current_arg_next;
  logic [MW-1:0]    arg_remaining, arg_remaining_next;
  logic             closed, closed_next;

  logic [MW-1:0] msg_limit;
  logic [AW-1:0] arg_limit;
  logic [31:0]   field_value;
  logic          field_done;
  logic [MW-1:0] msg_dec;
  logic [MW-1:0] arem_dec;
  logic [AW-1:0] args_dec;
  logic          fin_trailing;
  logic          fin_mend;
  phase_t        fin_phase;

  assign msg_limit = (max_message_bytes > MSG_CAP_C) ? MW'(MSG_CAP)
                                                     : MW'(max_message_bytes);
  assign arg_limit = (max_arguments > ARG_CAP_C) ? AW'(ARG_CAP) : AW'(max_arguments);

  assign field_done  = (field_byte_count == 2'd3);
  assign field_value = {data_byte, field_shift};

  assign msg_dec  = (message_remaining != '0) ? message_remaining - MW'(1) : message_remaining;
  assign arem_dec = (arg_remaining != '0) ? arg_remaining - MW'(1) : arg_remaining;
  assign args_dec = (args_remaining != '0) ? args_remaining - AW'(1) : args_remaining;

  // Closing an argument: trailing body bytes after the last one are malformed.
  assign fin_trailing = (args_dec == '0) && (msg_dec != '0);
  assign fin_mend     = (args_dec == '0);
  assign fin_phase    = (args_dec == '0) ? PH_LEN : PH_ALEN;

  always_comb begin
    phase_next             = phase;
    field_byte_count_next  = field_byte_count;
    field_shift_next       = field_shift;
    message_remaining_next = message_remaining;
    args_remaining_next    = args_remaining;
    current_arg_next       = current_arg;
    arg_remaining_next     = arg_remaining;
    closed_next            = closed;
    res_valid              = 1'b0;
    res                    = '0;

    unique case (field_byte_count)
      2'd0:    field_shift_next = {16'd0, data_byte};
      2'd1:    field_shift_next = {8'd0, data_byte, field_shift[7:0]};
      2'd2:    field_shift_next = {data_byte, field_shift[15:0]};
      default: field_shift_next = field_shift;
    endcase

    if (!closed) begin
      unique case (phase)
        PH_LEN: begin
          field_byte_count_next = field_byte_count + 2'd1;
          if (field_done) begin
            if (field_value > 32'(msg_limit)) begin
              closed_next      = 1'b1;
              res_valid        = 1'b1;
              res.kind         = KIND_ERROR;
              res.error_code   = ERR_TOO_LONG;
            end else if (field_value < MIN_LEN) begin
              closed_next      = 1'b1;
              res_valid        = 1'b1;
              res.kind         = KIND_ERROR;
              res.error_code   = ERR_MALFORMED;
            end else begin
              message_remaining_next = field_value[MW-1:0];
              phase_next             = PH_COUNT;
            end
          end
        end
        PH_COUNT: begin
          message_remaining_next = msg_dec;
          field_byte_count_next  = field_byte_count + 2'd1;
          if (field_done) begin
            current_arg_next = '0;
            if (field_value > 32'(arg_limit) ||
                (field_value == 32'd0 && msg_dec != '0)) begin
              closed_next    = 1'b1;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_MALFORMED;
            end else if (field_value == 32'd0) begin
              phase_next      = PH_LEN;
              res_valid       = 1'b1;
              res.kind        = KIND_EMPTY_MSG;
              res.message_end = 1'b1;
            end else begin
              args_remaining_next = field_value[AW-1:0];
              phase_next          = PH_ALEN;
            end
          end
        end
        PH_ALEN: begin
          if (field_byte_count == 2'd0 && message_remaining < MW'(4)) begin
            closed_next    = 1'b1;
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_MALFORMED;
          end else begin
            message_remaining_next = msg_dec;
            field_byte_count_next  = field_byte_count + 2'd1;
            if (field_done) begin
              if (field_value > 32'(msg_dec) ||
                  (field_value == 32'd0 && fin_trailing)) begin
                closed_next    = 1'b1;
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_MALFORMED;
              end else if (field_value == 32'd0) begin
                args_remaining_next = args_dec;
                current_arg_next    = current_arg + IDX_W'(1);
                phase_next          = fin_phase;
                res_valid           = 1'b1;
                res.kind            = KIND_EMPTY_ARG;
                res.arg_index       = current_arg;
                res.arg_end         = 1'b1;
                res.message_end     = fin_mend;
              end else begin
                arg_remaining_next = field_value[MW-1:0];
                phase_next         = PH_DATA;
              end
            end
          end
        end
        PH_DATA: begin
          message_remaining_next = msg_dec;
          arg_remaining_next     = arem_dec;
          if (arem_dec == '0 && fin_trailing) begin
            closed_next    = 1'b1;
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_MALFORMED;
          end else begin
            res_valid     = 1'b1;
            res.kind      = KIND_ARG_BYTE;
            res.arg_byte  = data_byte;
            res.arg_index = current_arg;
            if (arem_dec == '0) begin
              args_remaining_next = args_dec;
              current_arg_next    = current_arg + IDX_W'(1);
              phase_next          = fin_phase;
              res.arg_end         = 1'b1;
              res.message_end     = fin_mend;
            end
          end
        end
        default: phase_next = PH_LEN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_LEN;
      field_byte_count  <= '0;
      field_shift       <= '0;
      message_remaining <= '0;
      args_remaining    <= '0;
      current_arg       <= '0;
      arg_remaining     <= '0;
      closed            <= 1'b0;
    end else if (step) begin
      phase             <= phase_next;
      field_byte_count  <= field_byte_count_next;
      field_shift       <= field_shift_next;
      message_remaining <= message_remaining_next;
      args_remaining    <= args_remaining_next;
      current_arg       <= current_arg_next;
      arg_remaining     <= arg_remaining_next;
      closed            <= closed_next;
    end
  end

endmodule
